>>> rtl/core/ecd_pkg.sv
// Shared types and constants for the echo escape decoder.
// No dependencies; the front, queue, back and core files use this package.
package ecd_pkg;

    // Octal escape length, the leading '0' included (1 to 3)
    localparam int OCTAL_MAX_DIGITS = 3;

    // Bytes of one decoded input item, handed from front to back
    typedef struct packed {
        logic       two;    // byte1 follows byte0
        logic [7:0] byte0;
        logic [7:0] byte1;
    } ecd_entry_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } ecd_q_status_t;

endpackage

>>> rtl/core/ecd_if.sv
// Stream interfaces of the escape decoder: text items in, decoded bytes out.
// Depends on nothing; valid/ready handshake, item moves when both are high.
interface ecd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_byte;

    modport source (output valid, output kind, output char_byte, input ready);
    modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface ecd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/core/ecd_front.sv
// Front of the escape decoder: accepts text items, tracks escape state and
// classifies each item into zero, one or two output bytes. Uses ecd_pkg.
module ecd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  escapes_on,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_kind,
    input  logic [7:0]            in_char,
    input  ecd_pkg::ecd_q_status_t q_status,
    output logic                  push,
    output ecd_pkg::ecd_entry_t   push_entry
);

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESCAPE = 4'b0010,
        MODE_OCTAL  = 4'b0100,
        MODE_DROP   = 4'b1000
    } mode_t;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_7    = 8'h37;
    localparam logic [1:0] MAX_DIG   = 2'(ecd_pkg::OCTAL_MAX_DIGITS);

    mode_t      mode_reg, mode_next;
    logic [5:0] oct_val_reg, oct_val_next;
    logic [1:0] oct_dig_reg, oct_dig_next;

    logic       accept;
    logic [1:0] n_res;
    logic [7:0] byte0, byte1;
    logic [5:0] oct_sum;
    logic [1:0] oct_inc;
    logic       is_digit;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign oct_sum  = {oct_val_reg[2:0], in_char[2:0]};
    assign oct_inc  = oct_dig_reg + 2'd1;
    assign is_digit = (in_char >= CHAR_0) && (in_char <= CHAR_7);

    // Decode one item: next escape state and the bytes it yields
    always_comb
    begin
        mode_next    = mode_reg;
        oct_val_next = oct_val_reg;
        oct_dig_next = oct_dig_reg;
        n_res        = 2'd0;
        byte0        = 8'h00;
        byte1        = 8'h00;
        if (accept)
        begin
            if (in_kind)
            begin
                // End of string: flush a pending backslash or octal value
                case (mode_reg)
                    MODE_ESCAPE:
                    begin
                        n_res = 2'd1;
                        byte0 = BACKSLASH;
                    end
                    MODE_OCTAL:
                    begin
                        n_res = 2'd1;
                        byte0 = {2'b00, oct_val_reg};
                    end
                    default:
                    begin
                        n_res = 2'd0;
                    end
                endcase
                mode_next    = MODE_NORMAL;
                oct_val_next = 6'd0;
                oct_dig_next = 2'd0;
            end
            else if (!escapes_on)
            begin
                // Pass through and drop any pending escape
                mode_next    = MODE_NORMAL;
                oct_val_next = 6'd0;
                oct_dig_next = 2'd0;
                n_res        = 2'd1;
                byte0        = in_char;
            end
            else
            begin
                case (mode_reg)
                    MODE_NORMAL:
                    begin
                        if (in_char == BACKSLASH)
                        begin
                            mode_next = MODE_ESCAPE;
                        end
                        else
                        begin
                            n_res = 2'd1;
                            byte0 = in_char;
                        end
                    end
                    MODE_ESCAPE:
                    begin
                        mode_next = MODE_NORMAL;
                        n_res     = 2'd1;
                        case (in_char)
                            8'h61: byte0 = 8'd7;    // a
                            8'h62: byte0 = 8'd8;    // b
                            8'h65: byte0 = 8'd27;   // e
                            8'h66: byte0 = 8'd12;   // f
                            8'h6E: byte0 = 8'd10;   // n
                            8'h72: byte0 = 8'd13;   // r
                            8'h74: byte0 = 8'd9;    // t
                            8'h76: byte0 = 8'd11;   // v
                            BACKSLASH, 8'h27, 8'h22, 8'h3F: byte0 = in_char;
                            8'h63:
                            begin
                                // Backslash-c: silence until end of string
                                mode_next = MODE_DROP;
                                n_res     = 2'd0;
                            end
                            CHAR_0:
                            begin
                                oct_val_next = 6'd0;
                                if (2'd1 >= MAX_DIG)
                                begin
                                    oct_dig_next = 2'd0;
                                    byte0        = 8'h00;
                                end
                                else
                                begin
                                    oct_dig_next = 2'd1;
                                    mode_next    = MODE_OCTAL;
                                    n_res        = 2'd0;
                                end
                            end
                            default:
                            begin
                                // Unknown escape: keep backslash and byte
                                n_res = 2'd2;
                                byte0 = BACKSLASH;
                                byte1 = in_char;
                            end
                        endcase
                    end
                    MODE_OCTAL:
                    begin
                        if (is_digit)
                        begin
                            oct_val_next = oct_sum;
                            oct_dig_next = oct_inc;
                            if (oct_inc >= MAX_DIG)
                            begin
                                n_res        = 2'd1;
                                byte0        = {2'b00, oct_sum};
                                mode_next    = MODE_NORMAL;
                                oct_val_next = 6'd0;
                                oct_dig_next = 2'd0;
                            end
                        end
                        else
                        begin
                            // Early end: emit value, then treat byte as normal
                            n_res        = 2'd1;
                            byte0        = {2'b00, oct_val_reg};
                            mode_next    = MODE_NORMAL;
                            oct_val_next = 6'd0;
                            oct_dig_next = 2'd0;
                            if (in_char == BACKSLASH)
                            begin
                                mode_next = MODE_ESCAPE;
                            end
                            else
                            begin
                                n_res = 2'd2;
                                byte1 = in_char;
                            end
                        end
                    end
                    default:
                    begin
                        n_res = 2'd0;
                    end
                endcase
            end
        end
    end

    // Hand nonempty results to the queue
    assign push             = n_res != 2'd0;
    assign push_entry.two   = n_res == 2'd2;
    assign push_entry.byte0 = byte0;
    assign push_entry.byte1 = byte1;

    // Hold escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            oct_val_reg <= 6'd0;
            oct_dig_reg <= 2'd0;
        end
        else
        begin
            mode_reg    <= mode_next;
            oct_val_reg <= oct_val_next;
            oct_dig_reg <= oct_dig_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_kind |=> mode_reg == MODE_NORMAL && oct_dig_reg == 2'd0)
        else $error("end item did not clear escape state");

    a_oct_digits: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_OCTAL |-> oct_dig_reg != 2'd0 && oct_dig_reg < MAX_DIG)
        else $error("octal digit count out of range");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_kind && !escapes_on |-> push && !push_entry.two)
        else $error("pass-through item did not yield one byte");

endmodule

>>> rtl/core/ecd_queue.sv
// Short queue of decoded entries between the front and back of the decoder.
// Uses ecd_pkg for the entry and status types.
module ecd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ecd_pkg::ecd_entry_t    push_entry,
    input  logic                   pop,
    output ecd_pkg::ecd_entry_t    head,
    output ecd_pkg::ecd_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    ecd_pkg::ecd_entry_t   mem [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    assign status.full  = count_reg == FULL_CNT;
    assign status.empty = count_reg == '0;
    assign head         = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

>>> rtl/core/ecd_back.sv
// Back of the escape decoder: plays out queued entries one byte per cycle
// while out_ready is high and marks the last byte of each item. Uses ecd_pkg.
module ecd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ecd_pkg::ecd_entry_t    head,
    input  ecd_pkg::ecd_q_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   last_of_run
);

    logic second_reg, second_next;
    logic take;

    // Show the current byte of the head entry
    assign out_valid   = !q_status.empty;
    assign out_byte    = second_reg ? head.byte1 : head.byte0;
    assign last_of_run = second_reg || !head.two;
    assign take        = out_valid && out_ready;
    assign pop         = take && last_of_run;

    // Step to the second byte, back to the first on pop
    always_comb
    begin
        second_next = second_reg;
        if (take)
        begin
            second_next = !last_of_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
        end
    end

    a_second_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !q_status.empty && head.two)
        else $error("second byte pending without a two-byte entry");

endmodule

>>> rtl/core/echo_escape_decoder_core.sv
// Echo-style backslash escape decoder. Takes one text item per cycle on
// text while the queue has room (kind 0 = byte, kind 1 = end of string) and
// yields decoded bytes on decoded, last_of_run high on the final byte caused
// by each item. Items that yield one byte or none sustain one item per cycle
// while decoded is ready; an item that yields two bytes (unknown escape,
// octal escape ended by a plain byte) holds the single output port of the
// back end for both; the QUEUE_DEPTH-entry queue absorbs the difference.
// escapes_on resets to 1 and is written through cfg_we / cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
module echo_escape_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    ecd_in_if.sink    text,
    ecd_out_if.source decoded,
    input  logic      cfg_we,
    input  logic      cfg_data
);

    logic                   escapes_on_reg;
    logic                   push;
    logic                   pop;
    ecd_pkg::ecd_entry_t    push_entry;
    ecd_pkg::ecd_entry_t    head;
    ecd_pkg::ecd_q_status_t q_status;

    // Hold the escape enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escapes_on_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            escapes_on_reg <= cfg_data;
        end
    end

    ecd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .escapes_on (escapes_on_reg),
        .in_valid   (text.valid),
        .in_ready   (text.ready),
        .in_kind    (text.kind),
        .in_char    (text.char_byte),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    ecd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    ecd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (decoded.valid),
        .out_ready   (decoded.ready),
        .out_byte    (decoded.out_byte),
        .last_of_run (decoded.last_of_run)
    );

endmodule
